### rtl/ostm_pkg.sv
// Shared constants, codes, types and helpers for the one-shot match timer slot table.
package ostm_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int TIME_W      = 64;
  localparam int SLOT_OUT_W  = 3;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IN_DATA_W   = 2 * TIME_W;
  localparam int OUT_DATA_W  = 8;

  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ARMED   = 2'd0,
    KIND_NOFREE  = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic arm_take;
    logic arm_nofree;
    logic expire;
    logic advance;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic stopped;
    logic hit;
    logic at_end;
    logic cap_last;
    logic pend_valid;
    logic out_free;
  } stat_t;

  function automatic logic [SLOT_OUT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    to_slot = SLOT_OUT_W'(idx);
  endfunction

endpackage

### rtl/ostm_ctrl.sv
// Controller state machine that sequences the slot scan for arm and tick requests.
module ostm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ostm_pkg::stat_t stat,
  output ostm_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.op_tick) begin
          if (stat.stopped) begin
            if (stat.out_free) begin
              cmd.arm_take = 1'b1;
              state_next   = ST_IDLE;
            end
          end else if (stat.at_end) begin
            if (stat.out_free) begin
              cmd.arm_nofree = 1'b1;
              state_next     = ST_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
          cmd.expire = stat.hit;
          if (stat.at_end || (stat.hit && stat.cap_last)) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/ostm_dp.sv
// Datapath: slot match times, running bits, scan index, pending expiry and result register.
module ostm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ostm_pkg::cmd_t                      cmd,
  output ostm_pkg::stat_t                     stat,
  input  logic                                in_op,
  input  logic [ostm_pkg::TIME_W-1:0]         in_match_time,
  input  logic [ostm_pkg::TIME_W-1:0]         in_current_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_kind,
  output logic [ostm_pkg::SLOT_OUT_W-1:0]     out_slot,
  output logic                                out_last
);

  logic [ostm_pkg::TIME_W-1:0]     slot_match [ostm_pkg::SLOTS];
  logic [ostm_pkg::SLOTS-1:0]      running;
  logic                            op;
  logic [ostm_pkg::TIME_W-1:0]     op_time;
  logic [ostm_pkg::IDX_W-1:0]      idx;
  logic [ostm_pkg::CNT_W-1:0]      cnt;
  logic                            pend_valid;
  logic [ostm_pkg::SLOT_OUT_W-1:0] pend_slot;

  logic                            out_free;
  logic                            push;
  ostm_pkg::kind_t                 push_kind;
  logic [ostm_pkg::SLOT_OUT_W-1:0] push_slot;
  logic                            push_last;

  assign out_free = !out_valid || out_ready;

  assign stat.op_tick    = (op == ostm_pkg::OP_TICK);
  assign stat.stopped    = !running[idx];
  assign stat.hit        = running[idx] && (op_time >= slot_match[idx]);
  assign stat.at_end     = (idx == ostm_pkg::IDX_W'(ostm_pkg::SLOTS - 1));
  assign stat.cap_last   = (cnt == ostm_pkg::CNT_W'(ostm_pkg::MAX_RESULTS - 1));
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  assign push = cmd.arm_take || cmd.arm_nofree || (cmd.expire && pend_valid) || cmd.flush;

  always_comb begin
    push_kind = ostm_pkg::KIND_EXPIRED;
    push_slot = pend_slot;
    push_last = cmd.flush;
    if (cmd.arm_take) begin
      push_kind = ostm_pkg::KIND_ARMED;
      push_slot = ostm_pkg::to_slot(idx);
      push_last = 1'b1;
    end else if (cmd.arm_nofree) begin
      push_kind = ostm_pkg::KIND_NOFREE;
      push_slot = '0;
      push_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.arm_take) begin
        running[idx] <= 1'b1;
      end else if (cmd.expire) begin
        running[idx] <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load || cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (cmd.expire) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arm_take) begin
      slot_match[idx] <= op_time;
    end
    if (cmd.load) begin
      op      <= in_op;
      op_time <= (in_op == ostm_pkg::OP_TICK) ? in_current_time : in_match_time;
      idx     <= '0;
      cnt     <= '0;
    end else begin
      if (cmd.advance) begin
        idx <= idx + 1'b1;
      end
      if (cmd.expire) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (cmd.expire) begin
      pend_slot <= ostm_pkg::to_slot(idx);
    end
    if (push) begin
      out_kind <= push_kind;
      out_slot <= push_slot;
      out_last <= push_last;
    end
  end

endmodule

### rtl/one_shot_match_timer_slots.sv
// Top level of the one-shot match timer slot table.
// A table of SLOTS one-shot timers, all stopped after reset. An arm request
// (tuser 0) stores tdata[63:0] as the match time in the lowest stopped slot
// and answers with that slot, or with "no free slot" when all run. A tick
// request (tuser 1) carries the present time in tdata[127:64]; every running
// slot whose match time is at or below it stops and is reported in slot
// order, the final report flagged with tlast; a tick that expires nothing
// gives no report. One request is handled at a time: the controller visits
// one slot per clock through a single 64-bit compare, except that it holds
// when a result is due while the result register still waits on m_tready.
// s_tready is high only while no request is in progress.
module one_shot_match_timer_slots (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ostm_pkg::IN_DATA_W-1:0]      s_tdata,  // match_time, current_time
  input  logic                                s_tuser,  // operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ostm_pkg::OUT_DATA_W-1:0]     m_tdata,  // slot_index, zero fill
  output logic [1:0]                          m_tuser,  // event_kind
  output logic                                m_tlast
);

  ostm_pkg::cmd_t                  cmd;
  ostm_pkg::stat_t                 stat;
  logic [ostm_pkg::SLOT_OUT_W-1:0] slot_index;

  ostm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ostm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (s_tuser),
    .in_match_time   (s_tdata[ostm_pkg::TIME_W-1:0]),
    .in_current_time (s_tdata[ostm_pkg::IN_DATA_W-1:ostm_pkg::TIME_W]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_kind        (m_tuser),
    .out_slot        (slot_index),
    .out_last        (m_tlast)
  );

  assign m_tdata = ostm_pkg::OUT_DATA_W'(slot_index);

endmodule

### rtl/ostm_chk.sv
// Port-level checker for the one-shot match timer slot table, bound to the top level.
module ostm_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ostm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                      m_tuser,
  input logic                            m_tlast
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before it was taken");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in progress");

  a_arm_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ostm_pkg::KIND_ARMED || m_tuser == ostm_pkg::KIND_NOFREE)
    |-> m_tlast)
    else $error("arm result without last marker");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ostm_pkg::KIND_NOFREE |-> m_tdata == '0)
    else $error("no-free-slot result with nonzero slot");

endmodule

bind one_shot_match_timer_slots ostm_chk u_ostm_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
